FILE: rtl/core/rmsd_pkg.sv
// ----------------------------------------------------------------------------
// rmsd_pkg
// Types and constants shared by the running mean / deviation / min / max block
// ----------------------------------------------------------------------------
`default_nettype none

package rmsd_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int SUM_W       = 40;
  localparam int SUMSQ_W     = 64;
  localparam int SQ_W        = 47;
  localparam int COUNT_W     = 17;
  localparam int FRAC_W      = 16;
  localparam int MEAN_W      = 40;
  localparam int SD_W        = 40;
  localparam int MAX_SAMPLES = 65536;

  // set queue between the accumulator and the solver
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // solver datapath
  localparam int DIV_W     = SUMSQ_W + 2 * FRAC_W;
  localparam int QUO_W     = 2 * SD_W;
  localparam int REM_W     = COUNT_W;
  localparam int MEAN_ITER = SUM_W + FRAC_W;
  localparam int SQ_ITER   = DIV_W;
  localparam int SQRT_ITER = SD_W;
  localparam int CNT_W     = $clog2(SQ_ITER);
  localparam int HALF_W    = MEAN_W / 2;
  localparam int PROD_W    = 2 * HALF_W;
  localparam int SREM_W    = SD_W + 2;

  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic [SUMSQ_W-1:0]         sum_sq;
    logic [COUNT_W-1:0]         count;
    logic signed [SAMPLE_W-1:0] min_val;
    logic signed [SAMPLE_W-1:0] max_val;
    logic                       ovf;
  } set_rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_DIV,
    ST_SQ_DIV,
    ST_MUL_P,
    ST_MUL_A,
    ST_SUB,
    ST_SQRT,
    ST_FINISH
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/rmsd_in_if.sv
// ----------------------------------------------------------------------------
// rmsd_in_if
// Sample channel: one sample item with its last-of-set mark
// ----------------------------------------------------------------------------
`default_nettype none

interface rmsd_in_if import rmsd_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rmsd_out_if.sv
// ----------------------------------------------------------------------------
// rmsd_out_if
// Result channel: one statistics item per closed set
// ----------------------------------------------------------------------------
`default_nettype none

interface rmsd_out_if import rmsd_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [MEAN_W-1:0]   mean_q16;
  logic [SD_W-1:0]            std_dev_q16;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] maximum;
  logic [COUNT_W-1:0]         sample_count;
  logic                       count_overflow;

  modport source (
    output valid, output mean_q16, output std_dev_q16, output minimum,
    output maximum, output sample_count, output count_overflow, input ready
  );
  modport sink (
    input valid, input mean_q16, input std_dev_q16, input minimum,
    input maximum, input sample_count, input count_overflow, output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/rmsd_front.sv
// ----------------------------------------------------------------------------
// rmsd_front
// Accumulator: squares each sample, keeps count, sums, min and max of the
// open set and pushes a set record into the queue on the last sample
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_front import rmsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  rmsd_in_if.sink  in_ch,
  output logic     push,
  output set_rec_t push_rec,
  input  logic     q_full
);

  logic                       s1_valid_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [SQ_W-1:0]            s1_sq_r;
  logic                       s1_last_r;

  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SUMSQ_W-1:0]         sumsq_r, sumsq_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic                       ovf_r, ovf_nxt;

  logic                       adv;
  logic                       accept;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  set_rec_t                   upd;

  assign adv          = !(s1_last_r && q_full);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign accept       = in_ch.valid && in_ch.ready;
  assign sq_full      = in_ch.sample * in_ch.sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (accept) begin
      s1_sample_r <= in_ch.sample;
      s1_sq_r     <= sq_full[SQ_W-1:0];
      s1_last_r   <= in_ch.last_sample;
    end
  end

  always_comb begin
    upd.count   = count_r;
    upd.sum     = sum_r;
    upd.sum_sq  = sumsq_r;
    upd.min_val = min_r;
    upd.max_val = max_r;
    upd.ovf     = ovf_r;
    if (count_r == '0 || s1_sample_r < min_r) begin
      upd.min_val = s1_sample_r;
    end
    if (count_r == '0 || s1_sample_r > max_r) begin
      upd.max_val = s1_sample_r;
    end
    if (count_r < COUNT_W'(MAX_SAMPLES)) begin
      upd.count  = count_r + COUNT_W'(1);
      upd.sum    = sum_r + SUM_W'(s1_sample_r);
      upd.sum_sq = sumsq_r + SUMSQ_W'(s1_sq_r);
    end else begin
      upd.ovf = 1'b1;
    end

    push      = s1_valid_r && adv && s1_last_r;
    push_rec  = upd;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ovf_nxt   = ovf_r;
    if (s1_valid_r && adv) begin
      min_nxt = upd.min_val;
      max_nxt = upd.max_val;
      if (s1_last_r) begin
        count_nxt = '0;
        sum_nxt   = '0;
        sumsq_nxt = '0;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = upd.count;
        sum_nxt   = upd.sum;
        sumsq_nxt = upd.sum_sq;
        ovf_nxt   = upd.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      ovf_r   <= ovf_nxt;
    end
    min_r <= min_nxt;
    max_r <= max_nxt;
  end

`ifndef ASSERT_OFF
  a_ovf_at_max: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == COUNT_W'(MAX_SAMPLES))
    else $error("overflow flag set below the sample limit");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rmsd_queue.sv
// ----------------------------------------------------------------------------
// rmsd_queue
// Small queue of closed-set records between accumulator and solver
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_queue import rmsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  set_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     rd_valid,
  output set_rec_t rd_rec
);

  set_rec_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_rec   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
    if (push) begin
      mem_r[wptr_r] <= push_rec;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("set record pushed into a full queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rmsd_back.sv
// ----------------------------------------------------------------------------
// rmsd_back
// Solver: radix-2 divides for mean and mean square, sliced square of the
// mean, digit-by-digit square root, and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module rmsd_back import rmsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      rec_valid,
  input  set_rec_t  rec,
  output logic      pop,
  rmsd_out_if.source out_ch
);

  back_state_t state_r, state_nxt;
  logic        out_load;

  logic                       neg_r;
  logic [SUMSQ_W-1:0]         sumsq_r;
  logic [COUNT_W-1:0]         n_r;
  logic signed [SAMPLE_W-1:0] min_r;
  logic signed [SAMPLE_W-1:0] max_r;
  logic                       ovf_r;

  logic [DIV_W-1:0]  div_r;
  logic [REM_W-1:0]  rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MEAN_W-1:0] q_r;
  logic [QUO_W-1:0]  a_r;
  logic [PROD_W-1:0] prod_r;
  logic [QUO_W-1:0]  acc_r;
  logic [1:0]        mstep_r;
  logic [QUO_W-1:0]  rad_r;
  logic [SD_W-1:0]   root_r;
  logic [SREM_W-1:0] srem_r;

  logic                       out_valid_r;
  logic signed [MEAN_W-1:0]   mean_out_r;
  logic [SD_W-1:0]            sd_out_r;
  logic signed [SAMPLE_W-1:0] min_out_r;
  logic signed [SAMPLE_W-1:0] max_out_r;
  logic [COUNT_W-1:0]         cnt_out_r;
  logic                       ovf_out_r;

  logic [SUM_W-1:0]    sum_u;
  logic [SUM_W-1:0]    mag;
  logic [REM_W:0]      div_t;
  logic                div_ge;
  logic [REM_W-1:0]    div_rem;
  logic [QUO_W-1:0]    quo_shift;
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [QUO_W-1:0]    addend;
  logic [SREM_W+1:0]   sq_r2;
  logic [SREM_W+1:0]   sq_trial;
  logic                sq_ge;
  logic [SREM_W-1:0]   sq_rem;

  // next state and handshakes
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (rec_valid) begin
          pop       = 1'b1;
          state_nxt = ST_MEAN_DIV;
        end
      end
      ST_MEAN_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_SQ_DIV;
        end
      end
      ST_SQ_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        state_nxt = ST_MUL_A;
      end
      ST_MUL_A: begin
        state_nxt = (mstep_r == 2'd2) ? ST_SUB : ST_MUL_P;
      end
      ST_SUB: begin
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath steps
  always_comb begin
    sum_u     = rec.sum;
    mag       = rec.sum[SUM_W-1] ? (~sum_u + SUM_W'(1)) : sum_u;

    div_t     = {rem_r, div_r[DIV_W-1]};
    div_ge    = div_t >= {1'b0, n_r};
    div_rem   = div_ge ? REM_W'(div_t - {1'b0, n_r}) : div_t[REM_W-1:0];
    quo_shift = {quo_r[QUO_W-2:0], div_ge};

    mul_a = (mstep_r == 2'd2) ? q_r[MEAN_W-1:HALF_W] : q_r[HALF_W-1:0];
    mul_b = (mstep_r == 2'd0) ? q_r[HALF_W-1:0] : q_r[MEAN_W-1:HALF_W];
    unique case (mstep_r)
      2'd0:    addend = QUO_W'(prod_r);
      2'd1:    addend = QUO_W'(prod_r) << (HALF_W + 1);
      2'd2:    addend = QUO_W'(prod_r) << (2 * HALF_W);
      default: addend = '0;
    endcase

    sq_r2    = {srem_r, rad_r[QUO_W-1:QUO_W-2]};
    sq_trial = {2'b00, root_r, 2'b01};
    sq_ge    = sq_r2 >= sq_trial;
    sq_rem   = sq_ge ? SREM_W'(sq_r2 - sq_trial) : sq_r2[SREM_W-1:0];
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          neg_r   <= rec.sum[SUM_W-1];
          sumsq_r <= rec.sum_sq;
          n_r     <= rec.count;
          min_r   <= rec.min_val;
          max_r   <= rec.max_val;
          ovf_r   <= rec.ovf;
          div_r   <= {mag, {(DIV_W - SUM_W){1'b0}}};
          rem_r   <= '0;
          cnt_r   <= CNT_W'(MEAN_ITER - 1);
        end
      end
      ST_MEAN_DIV: begin
        quo_r <= quo_shift;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          q_r   <= quo_shift[MEAN_W-1:0];
          div_r <= {sumsq_r, {(2 * FRAC_W){1'b0}}};
          rem_r <= '0;
          cnt_r <= CNT_W'(SQ_ITER - 1);
        end else begin
          div_r <= div_r << 1;
          rem_r <= div_rem;
        end
      end
      ST_SQ_DIV: begin
        quo_r <= quo_shift;
        div_r <= div_r << 1;
        rem_r <= div_rem;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          a_r     <= quo_shift;
          acc_r   <= '0;
          mstep_r <= 2'd0;
        end
      end
      ST_MUL_P: begin
        prod_r <= mul_a * mul_b;
      end
      ST_MUL_A: begin
        acc_r   <= acc_r + addend;
        mstep_r <= mstep_r + 2'd1;
      end
      ST_SUB: begin
        rad_r  <= (acc_r <= a_r) ? (a_r - acc_r) : '0;
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= CNT_W'(SQRT_ITER - 1);
      end
      ST_SQRT: begin
        rad_r  <= rad_r << 2;
        srem_r <= sq_rem;
        root_r <= {root_r[SD_W-2:0], sq_ge};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      mean_out_r <= neg_r ? (~q_r + MEAN_W'(1)) : q_r;
      sd_out_r   <= root_r;
      min_out_r  <= min_r;
      max_out_r  <= max_r;
      cnt_out_r  <= n_r;
      ovf_out_r  <= ovf_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mean_q16       = mean_out_r;
  assign out_ch.std_dev_q16    = sd_out_r;
  assign out_ch.minimum        = min_out_r;
  assign out_ch.maximum        = max_out_r;
  assign out_ch.sample_count   = cnt_out_r;
  assign out_ch.count_overflow = ovf_out_r;

`ifndef ASSERT_OFF
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MEAN_DIV || state_r == ST_SQ_DIV) |-> rem_r < n_r)
    else $error("divider remainder not below the count");
  a_sqrt_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> srem_r <= SREM_W'({root_r, 1'b0}))
    else $error("square root remainder above twice the root");
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result raised outside the finish step");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/running_mean_stddev_min_max_top.sv
// ----------------------------------------------------------------------------
// running_mean_stddev_min_max_top
// Running population mean, standard deviation, min and max over sample sets
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   sample, last_sample
//   out_ch   out  valid/ready   mean_q16, std_dev_q16, minimum, maximum,
//                               sample_count, count_overflow
//
// samples are taken one per cycle unless a closing sample waits on a full
// set queue; the accumulator has two register stages. each closed set goes
// through the solver in order: load, mean divide, mean-square divide, sliced square, subtract, root
// a two-entry set queue sits between them; sets that close faster than the solver clears them stall
// in_ch once the queue is full, and out_ch stalls hold the solver in its
// finish step and back up through the queue the same way
// reset is synchronous and active low and clears all control state
//
`default_nettype none

module running_mean_stddev_min_max_top import rmsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rmsd_in_if.sink     in_ch,
  rmsd_out_if.source  out_ch
);

  logic     push;
  set_rec_t push_rec;
  logic     q_full;
  logic     pop;
  logic     rd_valid;
  set_rec_t rd_rec;

  rmsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_rec (push_rec),
    .q_full   (q_full)
  );

  rmsd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_rec   (rd_rec)
  );

  rmsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rd_valid),
    .rec       (rd_rec),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the running mean / deviation / min / max block set by set: a tracker
// follows every accepted sample, works out the statistics of each closed set
// and compares them field by field with the result items, in order. Stimulus
// covers extreme samples and constant sets, then random sets with random
// gaps on the sample side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import rmsd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 520;
  localparam int DRAIN_CYCLES = 500;
  localparam int SAMPLE_MAX   = 2 ** (SAMPLE_W - 1) - 1;
  localparam int SAMPLE_MIN   = -(2 ** (SAMPLE_W - 1));

  typedef enum {VAL_FULL, VAL_NARROW, VAL_TOP, VAL_BOTTOM, VAL_FLAT} sample_style_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0]   mean_q16;
    logic [SD_W-1:0]            std_dev_q16;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    logic [COUNT_W-1:0]         sample_count;
    logic                       count_overflow;
  } set_stats_t;

  class set_stats_tracker;
    logic [COUNT_W-1:0]         n_acc;
    longint                     sum_acc;
    logic [SUMSQ_W-1:0]         sq_acc;
    logic signed [SAMPLE_W-1:0] lo_acc;
    logic signed [SAMPLE_W-1:0] hi_acc;
    logic                       ovf_acc;
    set_stats_t                 expected_stats[$];
    int                         mismatches;

    function new();
      clear_set();
      mismatches = 0;
    endfunction

    function void clear_set();
      n_acc   = '0;
      sum_acc = 0;
      sq_acc  = '0;
      lo_acc  = '0;
      hi_acc  = '0;
      ovf_acc = 1'b0;
    endfunction

    function set_stats_t close_set();
      logic [63:0]  mag;
      logic [63:0]  q;
      logic [127:0] scaled_sq;
      logic [127:0] q_sq;
      logic [127:0] spread;
      logic [127:0] root;
      logic [127:0] cand;
      set_stats_t   r;
      mag       = (sum_acc < 0) ? -sum_acc : sum_acc;
      q         = (mag << FRAC_W) / n_acc;
      scaled_sq = ({64'd0, sq_acc} << (2 * FRAC_W)) / n_acc;
      q_sq      = {64'd0, q} * {64'd0, q};
      spread    = (q_sq <= scaled_sq) ? scaled_sq - q_sq : '0;
      root      = '0;
      for (int b = SD_W - 1; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= spread) begin
          root = cand;
        end
      end
      r.mean_q16       = (sum_acc < 0) ? -q : q;
      r.std_dev_q16    = root[SD_W-1:0];
      r.minimum        = lo_acc;
      r.maximum        = hi_acc;
      r.sample_count   = n_acc;
      r.count_overflow = ovf_acc;
      return r;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic last);
      if (n_acc == 0) begin
        lo_acc = s;
        hi_acc = s;
      end else begin
        if (s < lo_acc) lo_acc = s;
        if (s > hi_acc) hi_acc = s;
      end
      // past the count limit only min and max still move and the overflow flag is set
      if (n_acc < MAX_SAMPLES) begin
        n_acc   = n_acc + 1'b1;
        sum_acc = sum_acc + s;
        sq_acc  = sq_acc + 64'(longint'(s) * longint'(s));
      end else begin
        ovf_acc = 1'b1;
      end
      if (last) begin
        expected_stats.push_back(close_set());
        clear_set();
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    task check_result(set_stats_t got);
      set_stats_t want;
      if (expected_stats.size() == 0) begin
        report_mismatch("result item with no closed set pending");
        return;
      end
      want = expected_stats.pop_front();
      if (got.mean_q16 !== want.mean_q16)
        report_mismatch($sformatf("mean_q16 %0d, expected %0d", got.mean_q16, want.mean_q16));
      if (got.std_dev_q16 !== want.std_dev_q16)
        report_mismatch($sformatf("std_dev_q16 %0d, expected %0d",
                                  got.std_dev_q16, want.std_dev_q16));
      if (got.minimum !== want.minimum)
        report_mismatch($sformatf("minimum %0d, expected %0d", got.minimum, want.minimum));
      if (got.maximum !== want.maximum)
        report_mismatch($sformatf("maximum %0d, expected %0d", got.maximum, want.maximum));
      if (got.sample_count !== want.sample_count)
        report_mismatch($sformatf("sample_count %0d, expected %0d",
                                  got.sample_count, want.sample_count));
      if (got.count_overflow !== want.count_overflow)
        report_mismatch($sformatf("count_overflow %0b, expected %0b",
                                  got.count_overflow, want.count_overflow));
    endtask

    function int pending();
      return expected_stats.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   items_sent = 0;

  set_stats_tracker tracker = new();

  rmsd_in_if  in_ch ();
  rmsd_out_if out_ch ();

  running_mean_stddev_min_max_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tracker.note_sample(in_ch.sample, in_ch.last_sample);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_result('{out_ch.mean_q16, out_ch.std_dev_q16, out_ch.minimum,
                             out_ch.maximum, out_ch.sample_count, out_ch.count_overflow});
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(sample_style_t style);
    int v;
    case (style)
      VAL_NARROW: begin
        v = int'($urandom_range(0, 32)) - 16;
      end
      VAL_TOP: begin
        v = SAMPLE_MAX - int'($urandom_range(0, 15));
      end
      VAL_BOTTOM: begin
        v = SAMPLE_MIN + int'($urandom_range(0, 15));
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last,
                             input int gap);
    if (gap != 0) begin
      in_ch.valid       <= 1'b0;
      in_ch.sample      <= SAMPLE_W'($urandom());
      in_ch.last_sample <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.last_sample <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_set(input int len, input sample_style_t style, input bit steady);
    logic signed [SAMPLE_W-1:0] flat_val;
    logic signed [SAMPLE_W-1:0] s;
    int                         gap;
    flat_val = draw_sample(VAL_FULL);
    for (int i = 0; i < len; i++) begin
      s   = (style == VAL_FLAT) ? flat_val : draw_sample(style);
      gap = steady ? 0 : $urandom_range(0, 7);
      send_sample(s, i == len - 1, gap);
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      int stall;
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int            random_start;
    int            len;
    int            pick;
    sample_style_t style;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.last_sample = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // single-sample sets at the extremes and around zero
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b1, 0);
    send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b1, 3);
    send_sample(SAMPLE_W'(0), 1'b1, 0);
    send_sample(SAMPLE_W'(-1), 1'b1, 1);
    // widest spread over two samples
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0, 0);
    send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b1, 2);
    send_sample(SAMPLE_W'(-3), 1'b0, 0);
    send_sample(SAMPLE_W'(7), 1'b0, 5);
    send_sample(SAMPLE_W'(1), 1'b1, 0);
    send_sample(24'h555555, 1'b0, 0);
    send_sample(24'hAAAAAA, 1'b1, 7);
    // constant set, zero deviation
    send_set(3, VAL_FLAT, 1'b1);
    send_set(5, VAL_FULL, 1'b0);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        len = $urandom_range(1, 3);
      end else if (pick < 90) begin
        len = $urandom_range(4, 16);
      end else begin
        len = $urandom_range(17, 80);
      end
      style = sample_style_t'($urandom_range(0, 4));
      send_set(len, style, $urandom_range(0, 3) == 0);
    end
    in_ch.valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
